### hw/rtl/tqo_pkg.sv
// Shared types, constants and helpers for the two-wheel quadrature odometer.
package tqo_pkg;

    localparam int COUNT_BITS  = 16;
    localparam int FRAC_BITS   = 16;
    localparam int PERIOD_BITS = 16;

    localparam int SCALE_W  = 24;
    localparam int PERIOD_W = 16;
    localparam int LIMIT_W  = 31;
    localparam int DATA_W   = 32;
    localparam int PULSE_W  = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam longint LIMIT_UNITS = 10000;
    localparam longint LIMIT_FULL  = LIMIT_UNITS << FRAC_BITS;
    localparam longint LIMIT_MAX   = 64'h7FFF_FFFF;
    localparam logic [SCALE_W-1:0] SCALE_RESET =
        SCALE_W'((64'd1 << FRAC_BITS) & 64'hFF_FFFF);
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(6554);
    localparam logic [LIMIT_W-1:0] LIMIT_RESET =
        LIMIT_W'((LIMIT_FULL > LIMIT_MAX) ? LIMIT_MAX : LIMIT_FULL);

    localparam logic [1:0] OP_EDGE  = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_LATCH = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_SCALE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DISTANCE_LIMIT = 2'd2;

    typedef struct packed {
        logic [1:0] operation;
        logic       right_a_edge;
        logic       right_b_edge;
        logic       right_a_level;
        logic       right_b_level;
        logic       left_a_edge;
        logic       left_b_edge;
        logic       left_a_level;
        logic       left_b_level;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0]  left_speed;
        logic signed [DATA_W-1:0]  right_speed;
        logic signed [DATA_W-1:0]  left_distance;
        logic signed [DATA_W-1:0]  right_distance;
        logic signed [DATA_W-1:0]  average_distance;
        logic signed [DATA_W-1:0]  segment_start;
        logic signed [PULSE_W-1:0] left_pulses;
        logic signed [PULSE_W-1:0] right_pulses;
    } t_out_item;

    typedef struct packed {
        logic a_edge;
        logic b_edge;
        logic a_level;
        logic b_level;
    } t_enc;

    typedef struct packed {
        logic decode;
        logic speed;
        logic integrate;
        logic clear;
    } t_lane_cmd;

    typedef struct packed {
        logic average;
        logic clear;
        logic latch;
    } t_merge_cmd;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sh0000_0000_7FFF_FFFF;
        lo = -64'sh0000_0000_8000_0000;
        if (v > hi) begin
            return DATA_W'(hi);
        end else if (v < lo) begin
            return DATA_W'(lo);
        end
        return DATA_W'(v);
    endfunction

    function automatic logic signed [PULSE_W-1:0] to_pulses(
        input logic signed [COUNT_BITS-1:0] c
    );
        logic signed [63:0] w;
        w = 64'(c);
        return w[PULSE_W-1:0];
    endfunction

endpackage

### hw/rtl/two_wheel_quadrature_odometer.sv
// Top level of the two-wheel quadrature odometer: sequencer, config and output register.
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) carries one operation per
//   transaction: edge event, sample tick, clear distances or latch segment start.
//   Output channel (o_out_valid / i_out_stall / o_out_data) returns one result per
//   input transaction: speeds, distances, mean, segment start and pulse counts.
//   Config channel (i_cfg_valid / o_cfg_ready) writes speed_scale, sample_period and
//   distance_limit by index; o_cfg_ready is always high, write only while idle.
// Sequencing:
//   Edge, clear and latch transactions execute, then load the output register; a
//   new transaction is taken in the load cycle, so the next one is accepted as the
//   last result is loaded.
//   A sample tick runs the speed multiply, distance multiply-accumulate, then the
//   mean and limit compare in the merge stage, then output load.
//   The two wheel lanes run side by side; the merge stage is the only shared step.
// Reset: counts, speeds, distances, mean and segment start clear; config registers
//   return to their defaults; no result is pending.
// Stall: a result waits in the output register; the next transaction is taken and
//   executed, and holds in its load cycle until the output register frees.
module two_wheel_quadrature_odometer
    import tqo_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EXEC = 3'd1;
    localparam logic [2:0] ST_DIST = 3'd2;
    localparam logic [2:0] ST_AVG  = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    logic [2:0]          r_state;
    logic [2:0]          n_state;
    t_in_item            r_item;
    logic                r_out_valid;
    t_out_item           r_out_data;
    logic [SCALE_W-1:0]  r_scale;
    logic [PERIOD_W-1:0] r_period;
    logic [LIMIT_W-1:0]  r_limit;

    logic        w_in_accept;
    logic        w_out_free;
    logic        w_load;
    logic        w_over;
    t_lane_cmd   w_lane_cmd;
    t_merge_cmd  w_merge_cmd;
    t_enc        w_left_enc;
    t_enc        w_right_enc;

    logic signed [COUNT_BITS-1:0] w_left_count;
    logic signed [COUNT_BITS-1:0] w_right_count;
    logic signed [DATA_W-1:0]     w_left_speed;
    logic signed [DATA_W-1:0]     w_right_speed;
    logic signed [DATA_W-1:0]     w_left_dist;
    logic signed [DATA_W-1:0]     w_right_dist;
    logic signed [DATA_W-1:0]     w_avg;
    logic signed [DATA_W-1:0]     w_seg;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_load      = (r_state == ST_EMIT) && w_out_free;
    assign o_in_stall  = !((r_state == ST_IDLE) || w_load);
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    assign w_right_enc = '{a_edge: r_item.right_a_edge, b_edge: r_item.right_b_edge,
                           a_level: r_item.right_a_level, b_level: r_item.right_b_level};
    assign w_left_enc  = '{a_edge: r_item.left_a_edge, b_edge: r_item.left_b_edge,
                           a_level: r_item.left_a_level, b_level: r_item.left_b_level};

    always_comb begin
        w_lane_cmd  = '0;
        w_merge_cmd = '0;
        n_state     = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                unique case (r_item.operation)
                    OP_EDGE:  w_lane_cmd.decode = 1'b1;
                    OP_TICK:  w_lane_cmd.speed  = 1'b1;
                    OP_CLEAR: begin
                        w_lane_cmd.clear  = 1'b1;
                        w_merge_cmd.clear = 1'b1;
                    end
                    OP_LATCH: w_merge_cmd.latch = 1'b1;
                    default:  w_lane_cmd = '0;
                endcase
                n_state = (r_item.operation == OP_TICK) ? ST_DIST : ST_EMIT;
            end
            ST_DIST: begin
                w_lane_cmd.integrate = 1'b1;
                n_state = ST_AVG;
            end
            ST_AVG: begin
                w_merge_cmd.average = 1'b1;
                w_lane_cmd.clear    = w_over;
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (w_load) begin
                    n_state = w_in_accept ? ST_EXEC : ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_scale     <= SCALE_RESET;
            r_period    <= PERIOD_RESET;
            r_limit     <= LIMIT_RESET;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_SPEED_SCALE:    r_scale  <= i_cfg_data[SCALE_W-1:0];
                    CFG_SAMPLE_PERIOD:  r_period <= i_cfg_data[PERIOD_W-1:0];
                    CFG_DISTANCE_LIMIT: r_limit  <= i_cfg_data[LIMIT_W-1:0];
                    default:            r_limit  <= r_limit;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_item <= i_in_data;
        end
        if (w_load) begin
            r_out_data.left_speed       <= w_left_speed;
            r_out_data.right_speed      <= w_right_speed;
            r_out_data.left_distance    <= w_left_dist;
            r_out_data.right_distance   <= w_right_dist;
            r_out_data.average_distance <= w_avg;
            r_out_data.segment_start    <= w_seg;
            r_out_data.left_pulses      <= to_pulses(w_left_count);
            r_out_data.right_pulses     <= to_pulses(w_right_count);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    tqo_lane u_left_lane (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_lane_cmd),
        .i_enc    (w_left_enc),
        .i_negate (1'b1),
        .i_scale  (r_scale),
        .i_period (r_period),
        .o_count  (w_left_count),
        .o_speed  (w_left_speed),
        .o_dist   (w_left_dist)
    );

    tqo_lane u_right_lane (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_lane_cmd),
        .i_enc    (w_right_enc),
        .i_negate (1'b0),
        .i_scale  (r_scale),
        .i_period (r_period),
        .o_count  (w_right_count),
        .o_speed  (w_right_speed),
        .o_dist   (w_right_dist)
    );

    tqo_merge u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_merge_cmd),
        .i_left_dist  (w_left_dist),
        .i_right_dist (w_right_dist),
        .i_limit      (r_limit),
        .o_over       (w_over),
        .o_avg        (w_avg),
        .o_seg        (w_seg)
    );

    a_rise_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == ST_EMIT))
        else $error("result appeared outside the load cycle");

    a_accept_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept |-> (r_state == ST_IDLE || r_state == ST_EMIT))
        else $error("transaction taken while busy");

    a_limit_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_AVG && w_over) |=>
            (w_left_dist == '0 && w_right_dist == '0 && w_avg == '0))
        else $error("distances not cleared after limit");

    a_tick_clears_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC && r_item.operation == OP_TICK) |=>
            (w_left_count == '0 && w_right_count == '0))
        else $error("counts not cleared by sample tick");

endmodule

### hw/rtl/tqo_lane.sv
// One wheel lane: 4x quadrature count, speed scaling and distance integration.
module tqo_lane
    import tqo_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_lane_cmd                   i_cmd,
    input  t_enc                        i_enc,
    input  logic                        i_negate,
    input  logic [SCALE_W-1:0]          i_scale,
    input  logic [PERIOD_W-1:0]         i_period,
    output logic signed [COUNT_BITS-1:0] o_count,
    output logic signed [DATA_W-1:0]    o_speed,
    output logic signed [DATA_W-1:0]    o_dist
);

    localparam int PROD_W  = COUNT_BITS + SCALE_W + 1;
    localparam int NEG_W   = PROD_W + 1;
    localparam int DPROD_W = DATA_W + PERIOD_W + 1;
    localparam int INC_W   = DPROD_W - PERIOD_BITS;
    localparam int DSUM_W  = ((INC_W > DATA_W) ? INC_W : DATA_W) + 1;
    localparam logic signed [COUNT_BITS-1:0] CNT_HI =
        {1'b0, {(COUNT_BITS-1){1'b1}}};
    localparam logic signed [COUNT_BITS-1:0] CNT_LO =
        {1'b1, {(COUNT_BITS-1){1'b0}}};
    localparam logic signed [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

    logic signed [COUNT_BITS-1:0] r_count;
    logic signed [DATA_W-1:0]     r_speed;
    logic signed [DATA_W-1:0]     r_dist;

    logic signed [COUNT_BITS-1:0] w_step_a;
    logic signed [COUNT_BITS-1:0] w_step_b;
    logic signed [PROD_W-1:0]     w_prod;
    logic signed [NEG_W-1:0]      w_prod_ext;
    logic signed [NEG_W-1:0]      w_spd_full;
    logic signed [DPROD_W-1:0]    w_dprod;
    logic signed [INC_W-1:0]      w_inc;
    logic signed [DSUM_W-1:0]     w_dsum;

    function automatic logic signed [COUNT_BITS-1:0] count_step(
        input logic signed [COUNT_BITS-1:0] c,
        input logic                         up
    );
        if (up) begin
            return (c < CNT_HI) ? c + CNT_ONE : CNT_HI;
        end
        return (c > CNT_LO) ? c - CNT_ONE : CNT_LO;
    endfunction

    always_comb begin
        w_step_a = i_enc.a_edge ? count_step(r_count, i_enc.b_level) : r_count;
        w_step_b = i_enc.b_edge ? count_step(w_step_a, !i_enc.a_level) : w_step_a;
    end

    assign w_prod     = r_count * $signed({1'b0, i_scale});
    assign w_prod_ext = NEG_W'(w_prod);
    assign w_spd_full = i_negate ? -w_prod_ext : w_prod_ext;

    assign w_dprod = r_speed * $signed({1'b0, i_period});
    assign w_inc   = INC_W'(w_dprod >>> PERIOD_BITS);
    assign w_dsum  = DSUM_W'(r_dist) + DSUM_W'(w_inc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_speed <= '0;
            r_dist  <= '0;
        end else begin
            if (i_cmd.decode) begin
                r_count <= w_step_b;
            end
            if (i_cmd.speed) begin
                r_speed <= sat32(64'(w_spd_full));
                r_count <= '0;
            end
            if (i_cmd.clear) begin
                r_dist <= '0;
            end else if (i_cmd.integrate) begin
                r_dist <= sat32(64'(w_dsum));
            end
        end
    end

    assign o_count = r_count;
    assign o_speed = r_speed;
    assign o_dist  = r_dist;

endmodule

### hw/rtl/tqo_merge.sv
// Merge stage: mean distance, limit check and segment start latch.
module tqo_merge
    import tqo_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_merge_cmd               i_cmd,
    input  logic signed [DATA_W-1:0] i_left_dist,
    input  logic signed [DATA_W-1:0] i_right_dist,
    input  logic [LIMIT_W-1:0]       i_limit,
    output logic                     o_over,
    output logic signed [DATA_W-1:0] o_avg,
    output logic signed [DATA_W-1:0] o_seg
);

    logic signed [DATA_W-1:0] r_avg;
    logic signed [DATA_W-1:0] r_seg;

    logic signed [DATA_W:0]   w_sum;
    logic signed [DATA_W-1:0] w_avg;

    assign w_sum  = (DATA_W+1)'(i_left_dist) + (DATA_W+1)'(i_right_dist);
    assign w_avg  = DATA_W'(w_sum >>> 1);
    assign o_over = i_cmd.average &&
        ($signed({w_avg[DATA_W-1], w_avg}) >
         $signed({{(DATA_W+1-LIMIT_W){1'b0}}, i_limit}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg <= '0;
            r_seg <= '0;
        end else begin
            if (i_cmd.clear) begin
                r_avg <= '0;
            end else if (i_cmd.average) begin
                r_avg <= o_over ? '0 : w_avg;
            end
            if (i_cmd.latch) begin
                r_seg <= r_avg;
            end
        end
    end

    assign o_avg = r_avg;
    assign o_seg = r_seg;

endmodule
